// File: rtl/ftls_pkg.sv
// Package: widths, register indexes and lighting mode codes of the flat Lambert shader.
package ftls_pkg;

	localparam int CoordBits   = 24;
	localparam int CosFracBits = 16;

	localparam int EdgeW   = CoordBits + 1;
	localparam int ProdW   = 2 * EdgeW;
	localparam int NormW   = 2 * CoordBits + 3;
	localparam int MagW    = NormW - 1;
	localparam int NLim    = 31;
	localparam int NW      = NLim + 1;
	localparam int ShiftW  = $clog2(MagW + 1);
	localparam int LdW     = 16;
	localparam int NnW     = 2 * NW;
	localparam int LlW     = 32;
	localparam int DotW    = NW + LdW + 1;
	localparam int DmagW   = DotW - 1;
	localparam int DHalf   = DmagW / 2;
	localparam int DHiW    = DmagW - DHalf;
	localparam int HalfNnW = NnW / 2;
	localparam int PW      = NnW + LlW;
	localparam int RemW    = PW + 1;
	localparam int DivSt   = 2 * CosFracBits + 1;
	localparam int QW      = DivSt;
	localparam int SqSt    = CosFracBits + 1;
	localparam int RW      = QW + 1;
	localparam int CosW    = CosFracBits + 1;
	localparam int TW      = CosFracBits + 10;
	localparam int XW      = TW + 10;
	localparam int YW      = 18;
	localparam int Latency = 9 + DivSt + SqSt + 4;

	typedef enum logic [2:0] {
		RegLightDirX  = 3'd0,
		RegLightDirY  = 3'd1,
		RegLightDirZ  = 3'd2,
		RegLightEn    = 3'd3,
		RegLightMode  = 3'd4,
		RegAmbientRgb = 3'd5,
		RegLightRgb   = 3'd6,
		RegBaseRgba   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ModeShade = 2'd0,
		ModeUnlit = 2'd1,
		ModeOff   = 2'd2,
		ModeAlt   = 2'd3
	} light_mode_t;

endpackage

// File: rtl/flat_triangle_lambert_shader_unit.sv
// Top level: pipelined flat Lambert shader with ambient term, one triangle per cycle.
//
//  channel   signals                                   handshake
//  config    cfg_wr_en, cfg_index, cfg_data            write when cfg_wr_en high
//  triangle  start, busy, vertex_{a,b,c}_{x,y,z}       transfer when start && !busy
//  shade     done, shade_red/green/blue/alpha          valid for the one cycle done is high
//
// A triangle enters every cycle; busy stays low.
// The result passes the geometry stages, the bit-per-stage divider and root stages of the
// cosine, and the channel and output registers before done rises.
// Reset clears the valid bits of all stages and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
module flat_triangle_lambert_shader_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [2:0]                          cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_a_x,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_a_y,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_a_z,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_b_x,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_b_y,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_b_z,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_c_x,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_c_y,
	input  logic signed [ftls_pkg::CoordBits-1:0] vertex_c_z,
	output logic                                done,
	output logic [7:0]                          shade_red,
	output logic [7:0]                          shade_green,
	output logic [7:0]                          shade_blue,
	output logic [7:0]                          shade_alpha
);
	import ftls_pkg::*;

	// configuration registers
	logic signed [LdW-1:0] ld_q [3];
	logic                  light_en_q;
	light_mode_t           mode_q;
	logic [23:0]           amb_q;
	logic [23:0]           lrgb_q;
	logic [31:0]           base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q[0]    <= '0;
			ld_q[1]    <= -LdW'(32767);
			ld_q[2]    <= '0;
			light_en_q <= 1'b1;
			mode_q     <= ModeShade;
			amb_q      <= '0;
			lrgb_q     <= 24'hFFFFFF;
			base_q     <= 32'hFFFFFFFF;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				RegLightDirX:  ld_q[0] <= signed'(cfg_data[LdW-1:0]);
				RegLightDirY:  ld_q[1] <= signed'(cfg_data[LdW-1:0]);
				RegLightDirZ:  ld_q[2] <= signed'(cfg_data[LdW-1:0]);
				RegLightEn:    light_en_q <= cfg_data[0];
				RegLightMode:  mode_q <= light_mode_t'(cfg_data[1:0]);
				RegAmbientRgb: amb_q <= cfg_data[23:0];
				RegLightRgb:   lrgb_q <= cfg_data[23:0];
				RegBaseRgba:   base_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_sd [DivSt];
	logic v_sq [SqSt];
	logic v_c1, v_c2, v_c3, v_c4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			for (int k = 0; k < DivSt; k++) v_sd[k] <= 1'b0;
			for (int k = 0; k < SqSt; k++) v_sq[k] <= 1'b0;
			v_c1 <= 1'b0; v_c2 <= 1'b0; v_c3 <= 1'b0; v_c4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
			v_sd[0] <= v_s9;
			for (int k = 1; k < DivSt; k++) v_sd[k] <= v_sd[k-1];
			v_sq[0] <= v_sd[DivSt-1];
			for (int k = 1; k < SqSt; k++) v_sq[k] <= v_sq[k-1];
			v_c1 <= v_sq[SqSt-1];
			v_c2 <= v_c1; v_c3 <= v_c2; v_c4 <= v_c3;
		end
	end

	// s1: edge vectors
	logic signed [EdgeW-1:0] e_s1 [2][3];

	always_ff @(posedge clk) begin
		e_s1[0][0] <= EdgeW'(vertex_b_x) - EdgeW'(vertex_a_x);
		e_s1[0][1] <= EdgeW'(vertex_b_y) - EdgeW'(vertex_a_y);
		e_s1[0][2] <= EdgeW'(vertex_b_z) - EdgeW'(vertex_a_z);
		e_s1[1][0] <= EdgeW'(vertex_c_x) - EdgeW'(vertex_a_x);
		e_s1[1][1] <= EdgeW'(vertex_c_y) - EdgeW'(vertex_a_y);
		e_s1[1][2] <= EdgeW'(vertex_c_z) - EdgeW'(vertex_a_z);
	end

	// s2: cross product terms
	logic signed [ProdW-1:0] pp_s2 [6];

	always_ff @(posedge clk) begin
		pp_s2[0] <= ProdW'(e_s1[0][1]) * ProdW'(e_s1[1][2]);
		pp_s2[1] <= ProdW'(e_s1[0][2]) * ProdW'(e_s1[1][1]);
		pp_s2[2] <= ProdW'(e_s1[0][2]) * ProdW'(e_s1[1][0]);
		pp_s2[3] <= ProdW'(e_s1[0][0]) * ProdW'(e_s1[1][2]);
		pp_s2[4] <= ProdW'(e_s1[0][0]) * ProdW'(e_s1[1][1]);
		pp_s2[5] <= ProdW'(e_s1[0][1]) * ProdW'(e_s1[1][0]);
	end

	// s3: normal in sign-magnitude form
	logic signed [NormW-1:0] nd [3];
	logic [MagW-1:0]         mag_s3 [3];
	logic                    neg_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			nd[i] = NormW'(pp_s2[2*i]) - NormW'(pp_s2[2*i+1]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s3[i] <= nd[i][NormW-1];
			mag_s3[i] <= nd[i][NormW-1] ? MagW'(-nd[i]) : MagW'(nd[i]);
		end
	end

	// s4: scale-down shift from the leading one of all magnitudes
	logic [MagW-1:0]   mor;
	logic [ShiftW-1:0] mlen;
	logic [MagW-1:0]   mag_s4 [3];
	logic              neg_s4 [3];
	logic [ShiftW-1:0] sh_s4;

	always_comb begin
		mor  = mag_s3[0] | mag_s3[1] | mag_s3[2];
		mlen = '0;
		for (int i = 0; i < MagW; i++)
			if (mor[i]) mlen = ShiftW'(i + 1);
	end

	always_ff @(posedge clk) begin
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		sh_s4  <= (mlen > ShiftW'(NLim)) ? mlen - ShiftW'(NLim) : '0;
	end

	// s5: scaled normal
	logic [MagW-1:0]      msh [3];
	logic signed [NW-1:0] n_s5 [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			msh[i] = mag_s4[i] >> sh_s4;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			n_s5[i] <= neg_s4[i] ? -signed'(NW'(msh[i])) : signed'(NW'(msh[i]));
	end

	// s6: squares and dot terms
	logic signed [NnW-1:0]  sq_s6 [3];
	logic signed [DotW-1:0] dp_s6 [3];
	logic signed [LlW-1:0]  lq_s6 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= NnW'(n_s5[i]) * NnW'(n_s5[i]);
			dp_s6[i] <= DotW'(n_s5[i]) * DotW'(ld_q[i]);
			lq_s6[i] <= LlW'(ld_q[i]) * LlW'(ld_q[i]);
		end
	end

	// s7: sums
	logic [NnW-1:0]         nn_s7;
	logic [LlW-1:0]         ll_s7;
	logic signed [DotW-1:0] d_s7;

	always_ff @(posedge clk) begin
		nn_s7 <= unsigned'(sq_s6[0]) + unsigned'(sq_s6[1]) + unsigned'(sq_s6[2]);
		ll_s7 <= unsigned'(lq_s6[0]) + unsigned'(lq_s6[1]) + unsigned'(lq_s6[2]);
		d_s7  <= dp_s6[0] + dp_s6[1] + dp_s6[2];
	end

	// s8: partial products of |N|^2|L|^2 and d^2
	logic [DmagW-1:0]          dm;
	logic [HalfNnW+LlW-1:0]    ppl_s8, pph_s8;
	logic [2*DHiW-1:0]         dhh_s8;
	logic [DHiW+DHalf-1:0]     dhl_s8;
	logic [2*DHalf-1:0]        dll_s8;
	logic                      z_s8;

	assign dm = d_s7[DotW-1] ? DmagW'(-d_s7) : DmagW'(d_s7);

	always_ff @(posedge clk) begin
		ppl_s8 <= (HalfNnW+LlW)'(nn_s7[HalfNnW-1:0]) * (HalfNnW+LlW)'(ll_s7);
		pph_s8 <= (HalfNnW+LlW)'(nn_s7[NnW-1:HalfNnW]) * (HalfNnW+LlW)'(ll_s7);
		dhh_s8 <= (2*DHiW)'(dm[DmagW-1:DHalf]) * (2*DHiW)'(dm[DmagW-1:DHalf]);
		dhl_s8 <= (DHiW+DHalf)'(dm[DmagW-1:DHalf]) * (DHiW+DHalf)'(dm[DHalf-1:0]);
		dll_s8 <= (2*DHalf)'(dm[DHalf-1:0]) * (2*DHalf)'(dm[DHalf-1:0]);
		z_s8   <= !light_en_q || (nn_s7 == '0) || (ll_s7 == '0) || !d_s7[DotW-1];
	end

	// s9: assemble products
	logic [PW-1:0] p_s9, dd_s9;
	logic          z_s9;

	always_ff @(posedge clk) begin
		p_s9  <= (PW'(pph_s8) << HalfNnW) + PW'(ppl_s8);
		dd_s9 <= (PW'(dhh_s8) << (2*DHalf)) + (PW'(dhl_s8) << (DHalf+1)) + PW'(dll_s8);
		z_s9  <= z_s8;
	end

	// divider: one quotient bit per stage
	logic [RemW-1:0] rem_sd [DivSt];
	logic [QW-1:0]   q_sd [DivSt];
	logic [PW-1:0]   p_sd [DivSt];
	logic            z_sd [DivSt];

	always_ff @(posedge clk) begin
		p_sd[0] <= p_s9;
		z_sd[0] <= z_s9;
		if (dd_s9 >= p_s9) begin
			rem_sd[0] <= RemW'(dd_s9 - p_s9);
			q_sd[0]   <= QW'(1);
		end else begin
			rem_sd[0] <= RemW'(dd_s9);
			q_sd[0]   <= '0;
		end
	end

	for (genvar k = 1; k < DivSt; k++) begin : g_div
		logic [RemW-1:0] shl;
		assign shl = {rem_sd[k-1][RemW-2:0], 1'b0};
		always_ff @(posedge clk) begin
			p_sd[k] <= p_sd[k-1];
			z_sd[k] <= z_sd[k-1];
			if (shl >= RemW'(p_sd[k-1])) begin
				rem_sd[k] <= shl - RemW'(p_sd[k-1]);
				q_sd[k]   <= {q_sd[k-1][QW-2:0], 1'b1};
			end else begin
				rem_sd[k] <= shl;
				q_sd[k]   <= {q_sd[k-1][QW-2:0], 1'b0};
			end
		end
	end

	// square root: one result bit per stage
	logic [QW-1:0] x_sq [SqSt];
	logic [RW-1:0] r_sq [SqSt];
	logic          z_sq [SqSt];

	for (genvar j = 0; j < SqSt; j++) begin : g_sqrt
		logic [QW-1:0] xin;
		logic [RW-1:0] rin;
		logic [RW-1:0] trial;
		logic          zin;
		if (j == 0) begin : g_first
			assign xin = q_sd[DivSt-1];
			assign rin = '0;
			assign zin = z_sd[DivSt-1];
		end else begin : g_next
			assign xin = x_sq[j-1];
			assign rin = r_sq[j-1];
			assign zin = z_sq[j-1];
		end
		assign trial = rin + (RW'(1) << (2*(SqSt-1-j)));
		always_ff @(posedge clk) begin
			z_sq[j] <= zin;
			if (RW'(xin) >= trial) begin
				x_sq[j] <= QW'(RW'(xin) - trial);
				r_sq[j] <= (rin >> 1) + (RW'(1) << (2*(SqSt-1-j)));
			end else begin
				x_sq[j] <= xin;
				r_sq[j] <= rin >> 1;
			end
		end
	end

	// channel math
	logic [CosW-1:0] cos_v;
	logic [7:0]      amb_c [3];
	logic [7:0]      lt_c [3];
	logic [7:0]      bs_c [3];
	logic [TW-1:0]   t_c1 [3];
	logic [XW-1:0]   xs [3];
	logic [YW-1:0]   y_c2 [3];
	logic [YW-1:0]   y_c3 [3];
	logic [YW-1:0]   q0_c3 [3];
	logic [YW-1:0]   rr [3];
	logic [YW-1:0]   vv [3];
	logic [7:0]      ch [3];

	always_comb begin
		if (z_sq[SqSt-1])
			cos_v = '0;
		else if (r_sq[SqSt-1] > (RW'(1) << CosFracBits))
			cos_v = CosW'(1) << CosFracBits;
		else
			cos_v = CosW'(r_sq[SqSt-1]);
		for (int i = 0; i < 3; i++) begin
			amb_c[i] = amb_q[8*(2-i) +: 8];
			lt_c[i]  = lrgb_q[8*(2-i) +: 8];
			bs_c[i]  = base_q[8*(3-i) +: 8];
			xs[i]    = (XW'(bs_c[i]) * XW'(t_c1[i]) << 1) + (XW'(255) << CosFracBits);
			rr[i]    = y_c3[i] - YW'(q0_c3[i] * YW'(255));
			vv[i]    = q0_c3[i] + ((rr[i] >= YW'(255)) ? YW'(1) : YW'(0));
			ch[i]    = (vv[i] > YW'(255)) ? 8'hFF : vv[i][7:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_c1[i]  <= (TW'(amb_c[i]) << CosFracBits) + TW'(lt_c[i]) * TW'(cos_v);
			y_c2[i]  <= YW'(xs[i] >> (CosFracBits + 1));
			y_c3[i]  <= y_c2[i];
			q0_c3[i] <= YW'((27'(y_c2[i]) * 27'(257)) >> 16);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		shade_alpha <= base_q[7:0];
		case (mode_q)
			ModeUnlit: begin
				shade_red   <= base_q[31:24];
				shade_green <= base_q[23:16];
				shade_blue  <= base_q[15:8];
			end
			ModeOff: begin
				shade_red   <= '0;
				shade_green <= '0;
				shade_blue  <= '0;
			end
			default: begin
				shade_red   <= ch[0];
				shade_green <= ch[1];
				shade_blue  <= ch[2];
			end
		endcase
	end

	assign done = v_c4;

endmodule

// File: rtl/ftls_checker.sv
// Checker: port-level timing of the flat Lambert shader, bound to the top level.
module ftls_port_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import ftls_pkg::*;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("transfer without result");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, Latency))
		else $error("result without transfer");

endmodule

bind flat_triangle_lambert_shader_unit ftls_port_props u_ftls_checker (.*);

// File: sim/ftls_checker.sv
// Checker: watches triangle transfers and config writes, predicts each shade and compares.
module ftls_checker
	import ftls_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [2:0]                  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        start,
	input  logic                        busy,
	input  logic signed [CoordBits-1:0] vertex_a_x,
	input  logic signed [CoordBits-1:0] vertex_a_y,
	input  logic signed [CoordBits-1:0] vertex_a_z,
	input  logic signed [CoordBits-1:0] vertex_b_x,
	input  logic signed [CoordBits-1:0] vertex_b_y,
	input  logic signed [CoordBits-1:0] vertex_b_z,
	input  logic signed [CoordBits-1:0] vertex_c_x,
	input  logic signed [CoordBits-1:0] vertex_c_y,
	input  logic signed [CoordBits-1:0] vertex_c_z,
	input  logic                        done,
	input  logic [7:0]                  shade_red,
	input  logic [7:0]                  shade_green,
	input  logic [7:0]                  shade_blue,
	input  logic [7:0]                  shade_alpha,
	output int                          mismatches,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} shade_t;

	logic signed [15:0] dir_x, dir_y, dir_z;
	logic               lit_en;
	light_mode_t        mode;
	logic [23:0]        amb_rgb, lit_rgb;
	logic [31:0]        base_col;
	shade_t             shade_q[$];

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] lambert_cos(input longint ax, ay, az, bx, by, bz,
			cx, cy, cz);
		longint e0[3], e1[3], nr[3], lv[3], d;
		logic [63:0] mg[3], nn, ll, q, c;
		logic [159:0] p, dd;
		e0 = '{bx - ax, by - ay, bz - az};
		e1 = '{cx - ax, cy - ay, cz - az};
		nr[0] = e0[1] * e1[2] - e0[2] * e1[1];
		nr[1] = e0[2] * e1[0] - e0[0] * e1[2];
		nr[2] = e0[0] * e1[1] - e0[1] * e1[0];
		for (int i = 0; i < 3; i++) mg[i] = nr[i] < 0 ? -nr[i] : nr[i];
		while (mg[0] >= 64'h8000_0000 || mg[1] >= 64'h8000_0000 || mg[2] >= 64'h8000_0000)
			for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
		lv = '{longint'(dir_x), longint'(dir_y), longint'(dir_z)};
		nn = 0;
		ll = 0;
		d = 0;
		for (int i = 0; i < 3; i++) begin
			nr[i] = nr[i] < 0 ? -longint'(mg[i]) : longint'(mg[i]);
			nn += nr[i] * nr[i];
			ll += lv[i] * lv[i];
			d += nr[i] * lv[i];
		end
		if (!lit_en || nn == 0 || ll == 0 || d >= 0) return 0;
		p = 160'(nn) * 160'(ll);
		dd = 160'(-d) * 160'(-d);
		q = 64'((dd << (2 * CosFracBits)) / p);
		c = root64(q);
		if (c > (64'd1 << CosFracBits)) c = 64'd1 << CosFracBits;
		return c;
	endfunction

	function automatic logic [7:0] tint(input logic [63:0] b, amb, lt, c);
		logic [63:0] one, t, v;
		one = 64'd1 << CosFracBits;
		t = amb * one + lt * c;
		v = (2 * b * t + 255 * one) / (2 * 255 * one);
		return v > 255 ? 8'd255 : v[7:0];
	endfunction

	function automatic shade_t shade_of_face();
		shade_t s;
		logic [63:0] c;
		s.alpha = base_col[7:0];
		if (mode == ModeUnlit) begin
			s.red = base_col[31:24];
			s.green = base_col[23:16];
			s.blue = base_col[15:8];
		end else if (mode == ModeOff) begin
			s.red = 0;
			s.green = 0;
			s.blue = 0;
		end else begin
			c = lambert_cos(vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
				vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z);
			s.red = tint(base_col[31:24], amb_rgb[23:16], lit_rgb[23:16], c);
			s.green = tint(base_col[23:16], amb_rgb[15:8], lit_rgb[15:8], c);
			s.blue = tint(base_col[15:8], amb_rgb[7:0], lit_rgb[7:0], c);
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shade_t got, want;
		if (!arst_n) begin
			dir_x <= 16'sd0;
			dir_y <= -16'sd32767;
			dir_z <= 16'sd0;
			lit_en <= 1'b1;
			mode <= ModeShade;
			amb_rgb <= 24'h0;
			lit_rgb <= 24'hFFFFFF;
			base_col <= 32'hFFFFFFFF;
			shade_q.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (start && !busy) shade_q.push_back(shade_of_face());
			if (done) begin
				got = '{shade_red, shade_green, shade_blue, shade_alpha};
				if (shade_q.size() == 0) begin
					if (mismatches < 10) $display("unexpected shade %h", got);
					mismatches <= mismatches + 1;
				end else begin
					want = shade_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("shade mismatch: expected %h actual %h", want, got);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= shade_q.size();
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					RegLightDirX: dir_x <= cfg_data[15:0];
					RegLightDirY: dir_y <= cfg_data[15:0];
					RegLightDirZ: dir_z <= cfg_data[15:0];
					RegLightEn: lit_en <= cfg_data[0];
					RegLightMode: mode <= light_mode_t'(cfg_data[1:0]);
					RegAmbientRgb: amb_rgb <= cfg_data[23:0];
					RegLightRgb: lit_rgb <= cfg_data[23:0];
					RegBaseRgba: base_col <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: sim/tb_top.sv
// Testbench top: drives triangles and register writes into the shader and gives the verdict.
module tb_top;
	import ftls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic cfg_wr_en = 0, start = 0, busy, done;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic signed [CoordBits-1:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0,
		cx = 0, cy = 0, cz = 0;
	logic [7:0] sr, sg, sb, sa;
	int mismatches, pending, cycles = 0, idle_pct = 12;

	always #4 clk = ~clk;

	flat_triangle_lambert_shader_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy),
		.vertex_a_x(ax), .vertex_a_y(ay), .vertex_a_z(az),
		.vertex_b_x(bx), .vertex_b_y(by), .vertex_b_z(bz),
		.vertex_c_x(cx), .vertex_c_y(cy), .vertex_c_z(cz),
		.done(done), .shade_red(sr), .shade_green(sg), .shade_blue(sb), .shade_alpha(sa)
	);

	ftls_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy),
		.vertex_a_x(ax), .vertex_a_y(ay), .vertex_a_z(az),
		.vertex_b_x(bx), .vertex_b_y(by), .vertex_b_z(bz),
		.vertex_c_x(cx), .vertex_c_y(cy), .vertex_c_z(cz),
		.done(done), .shade_red(sr), .shade_green(sg), .shade_blue(sb), .shade_alpha(sa),
		.mismatches(mismatches), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic send_face(input logic [23:0] v[9]);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{ax, ay, az, bx, by, bz, cx, cy, cz} <= {v[0], v[1], v[2], v[3], v[4], v[5],
			v[6], v[7], v[8]};
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_faces(input int count);
		logic [23:0] v[9];
		logic [23:0] base;
		int span;
		for (int i = 0; i < count; i++) begin
			span = $urandom_range(3) == 0 ? 23 : $urandom_range(18, 4);
			for (int k = 0; k < 9; k++) begin
				if (span == 23) begin
					v[k] = $urandom;
				end else begin
					if (k < 3) base = $urandom;
					v[k] = (k < 3) ? base : v[k % 3] + 24'($signed($urandom_range(
						(1 << span) - 1)) - (1 << (span - 1)));
				end
			end
			send_face(v);
		end
	endtask

	task automatic random_regs();
		write_reg(RegLightDirX, $urandom);
		write_reg(RegLightDirY, $urandom);
		write_reg(RegLightDirZ, $urandom);
		write_reg(RegLightEn, $urandom | 32'h1);
		write_reg(RegLightMode, $urandom & 32'hFFFF_FFFC);
		write_reg(RegAmbientRgb, $urandom);
		write_reg(RegLightRgb, $urandom);
		write_reg(RegBaseRgba, $urandom);
	endtask

	initial begin
		logic [23:0] d[9];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// facing away, facing toward, degenerate, extremes, huge normal
		send_face('{0, 0, 0, 256, 0, 0, 0, 0, 256});
		send_face('{0, 0, 0, 0, 0, 256, 256, 0, 0});
		send_face('{5, 5, 5, 5, 5, 5, 5, 5, 5});
		send_face('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
			24'h7FFFFF, 24'h800000, 24'h7FFFFF});
		send_face('{24'h800000, 0, 24'h800000, 24'h7FFFFF, 0, 24'h800000,
			24'h800000, 0, 24'h7FFFFF});
		send_face('{24'h800000, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 24'h7FFFFF,
			24'h800000, 0, 24'h800000});
		send_face('{0, 0, 0, 24'h7FFFFF, 24'h123456, 24'h800000, 24'h800000, 24'h7FFFFF,
			24'h654321});
		drain();
		write_reg(RegAmbientRgb, 32'hFF40_8020);
		write_reg(RegLightRgb, 32'hAB80_40FF);
		write_reg(RegBaseRgba, 32'hC080_FF7E);
		d = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
		send_face(d);
		drain();
		write_reg(RegLightEn, 32'hFFFF_FFFE);
		send_face(d);
		drain();
		for (int m = 0; m < 4; m++) begin
			write_reg(RegLightMode, 32'hFFFF_FFFC | m);
			send_face(d);
			drain();
		end
		write_reg(RegLightEn, 1);
		write_reg(RegLightMode, ModeShade);
		write_reg(RegLightDirY, 0);
		send_face(d);
		drain();
		write_reg(RegLightDirX, 16'h8000);
		write_reg(RegLightDirY, 16'h8000);
		write_reg(RegLightDirZ, 16'h8000);
		write_reg(RegAmbientRgb, 0);
		write_reg(RegLightRgb, 32'hFFFFFF);
		write_reg(RegBaseRgba, 32'hFFFFFFFF);
		random_faces(70);
		drain();
		write_reg(RegLightDirX, 16'h7FFF);
		write_reg(RegLightDirY, 16'h7FFF);
		write_reg(RegLightDirZ, 16'h7FFF);
		write_reg(RegAmbientRgb, 32'hFFFFFF);
		write_reg(RegBaseRgba, 0);
		random_faces(40);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			random_regs();
			idle_pct = (ph == 2) ? 0 : 12;
			random_faces(70);
			drain();
		end
		write_reg(RegLightMode, ModeAlt);
		random_faces(40);
		drain();
		write_reg(RegLightMode, ModeUnlit);
		random_faces(30);
		drain();
		write_reg(RegLightMode, ModeOff);
		random_faces(30);
		drain();
		repeat (Latency + 10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
